// ===== hw/rtl/tmc_pkg.sv =====
// shared types, constants and functions for the triangle measure block
package tmc_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int DSQ_W      = PROD_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int RAD_W      = DSQ_W + 2 * FRAC_BITS;
  localparam int ROOT_BITS  = RAD_W / 2;
  localparam int REM_W      = ROOT_BITS + 3;
  localparam int SQ_STEPS   = 5;
  localparam int SQ_STAGES  = (ROOT_BITS + SQ_STEPS - 1) / SQ_STEPS;
  localparam int PERIM_W    = 27;
  localparam int AREA_W     = 33;
  // front stages: diffs, products, sums
  localparam int FRONT_STAGES = 3;
  localparam int PIPE_STAGES  = FRONT_STAGES + SQ_STAGES;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
  } tmc_in_t;

  typedef struct packed {
    logic               valid_tri;
    logic [PERIM_W-1:0] perimeter_q8;
    logic [AREA_W-1:0]  area_halves;
    logic               is_right;
  } tmc_out_t;

  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [ROOT_BITS-1:0] root;
  } tmc_acc_t;

  // one digit of the restoring square root
  function automatic tmc_acc_t sq_step(input tmc_acc_t acc, input logic [1:0] pair);
    tmc_acc_t         res;
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] trial;
    r     = {acc.rem[REM_W-3:0], pair};
    trial = REM_W'({acc.root, 2'b01});
    if (r >= trial) begin
      res.rem  = r - trial;
      res.root = {acc.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      res.rem  = r;
      res.root = {acc.root[ROOT_BITS-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/tmc_sqrt_pipe.sv =====
// pipelined fixed-point square root, several digits per stage
module tmc_sqrt_pipe import tmc_pkg::*; (
  input  logic                 clk,
  input  logic [DSQ_W-1:0]     dsq,
  output logic [ROOT_BITS-1:0] root
);

  tmc_acc_t         acc_r   [SQ_STAGES];
  logic [RAD_W-1:0] rad_r   [SQ_STAGES];
  tmc_acc_t         acc_nxt [SQ_STAGES];
  logic [RAD_W-1:0] rad_nxt [SQ_STAGES];

  genvar k;
  generate
    for (k = 0; k < SQ_STAGES; k++) begin : g_stage
      tmc_acc_t         acc_in;
      logic [RAD_W-1:0] rad_in;

      // stage input: fresh radicand or previous stage
      if (k == 0) begin : g_head
        assign acc_in = '0;
        assign rad_in = {dsq, {(2*FRAC_BITS){1'b0}}};
      end else begin : g_tail
        assign acc_in = acc_r[k-1];
        assign rad_in = rad_r[k-1];
      end

      // digits of this stage
      always_comb begin
        tmc_acc_t acc;
        int       i;
        acc = acc_in;
        for (int j = 0; j < SQ_STEPS; j++) begin
          i = ROOT_BITS - 1 - SQ_STEPS * k - j;
          if (i >= 0) begin
            acc = sq_step(acc, rad_in[2*i +: 2]);
          end
        end
        acc_nxt[k] = acc;
        rad_nxt[k] = rad_in;
      end

      always_ff @(posedge clk) begin
        acc_r[k] <= acc_nxt[k];
        rad_r[k] <= rad_nxt[k];
      end
    end
  endgenerate

  assign root = acc_r[SQ_STAGES-1].root;

endmodule

// ===== hw/rtl/tmc_front.sv =====
// edge differences, products and sums ahead of the root stages
module tmc_front import tmc_pkg::*; (
  input  logic                      clk,
  input  tmc_in_t                   req,
  output logic [DSQ_W-1:0]          d1,
  output logic [DSQ_W-1:0]          d2,
  output logic [DSQ_W-1:0]          d3,
  output logic signed [CROSS_W-1:0] cross_prod
);

  logic signed [DIFF_W-1:0] e1x_r, e1y_r, e2x_r, e2y_r, e3x_r, e3y_r;
  logic signed [PROD_W-1:0] s1x_r, s1y_r, s2x_r, s2y_r, s3x_r, s3y_r, pa_r, pb_r;
  logic [DSQ_W-1:0]          d1_r, d2_r, d3_r;
  logic signed [CROSS_W-1:0] cross_r;

  // stage one: edge vectors
  always_ff @(posedge clk) begin
    e1x_r <= DIFF_W'(req.ax) - DIFF_W'(req.bx);
    e1y_r <= DIFF_W'(req.ay) - DIFF_W'(req.by_coord);
    e2x_r <= DIFF_W'(req.bx) - DIFF_W'(req.cx);
    e2y_r <= DIFF_W'(req.by_coord) - DIFF_W'(req.cy);
    e3x_r <= DIFF_W'(req.cx) - DIFF_W'(req.ax);
    e3y_r <= DIFF_W'(req.cy) - DIFF_W'(req.ay);
  end

  // stage two: squares and cross terms
  always_ff @(posedge clk) begin
    s1x_r <= PROD_W'(e1x_r) * PROD_W'(e1x_r);
    s1y_r <= PROD_W'(e1y_r) * PROD_W'(e1y_r);
    s2x_r <= PROD_W'(e2x_r) * PROD_W'(e2x_r);
    s2y_r <= PROD_W'(e2y_r) * PROD_W'(e2y_r);
    s3x_r <= PROD_W'(e3x_r) * PROD_W'(e3x_r);
    s3y_r <= PROD_W'(e3y_r) * PROD_W'(e3y_r);
    pa_r  <= PROD_W'(e1y_r) * PROD_W'(e3x_r);
    pb_r  <= PROD_W'(e1x_r) * PROD_W'(e3y_r);
  end

  // stage three: squared lengths and cross product
  always_ff @(posedge clk) begin
    d1_r    <= DSQ_W'(s1x_r) + DSQ_W'(s1y_r);
    d2_r    <= DSQ_W'(s2x_r) + DSQ_W'(s2y_r);
    d3_r    <= DSQ_W'(s3x_r) + DSQ_W'(s3y_r);
    cross_r <= CROSS_W'(pa_r) - CROSS_W'(pb_r);
  end

  assign d1         = d1_r;
  assign d2         = d2_r;
  assign d3         = d3_r;
  assign cross_prod = cross_r;

endmodule

// ===== hw/rtl/triangle_measure_classify.sv =====
// triangle measure and classify top level
//
//  channel  ports                      moves
//  input    start, busy, in_data       one triangle request per cycle
//  result   out_strobe, out_data       one result per request
//
// every request gives one result after it is taken
// (three arithmetic stages, five root stages of five digits each, output register)
// busy stays low: a new request may enter in every cycle
// the receiver cannot stall; results leave on out_strobe for one cycle
// synchronous active-low reset clears the valid bits only
module triangle_measure_classify import tmc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  tmc_in_t  in_data,
  output logic     out_strobe,
  output tmc_out_t out_data
);

  typedef struct packed {
    logic              valid_tri;
    logic [AREA_W-1:0] area;
    logic              is_right;
  } tmc_side_t;

  logic [DSQ_W-1:0]          d1, d2, d3;
  logic signed [CROSS_W-1:0] cross_prod;
  logic [ROOT_BITS-1:0]      r1, r2, r3;
  logic [PIPE_STAGES-1:0]    vld_r;
  tmc_side_t                 side_r   [SQ_STAGES];
  tmc_side_t                 side_nxt;
  logic                      out_strobe_r;
  tmc_out_t                  out_data_r;
  tmc_out_t                  out_data_nxt;
  logic [CROSS_W-1:0]        abs_cross;
  logic [DSQ_W:0]            sum1, sum2, sum3;

  assign busy = 1'b0;

  tmc_front u_front (
    .clk        (clk),
    .req        (in_data),
    .d1         (d1),
    .d2         (d2),
    .d3         (d3),
    .cross_prod (cross_prod)
  );

  tmc_sqrt_pipe u_sqrt1 (.clk(clk), .dsq(d1), .root(r1));
  tmc_sqrt_pipe u_sqrt2 (.clk(clk), .dsq(d2), .root(r2));
  tmc_sqrt_pipe u_sqrt3 (.clk(clk), .dsq(d3), .root(r3));

  // valid bits along the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= {vld_r[PIPE_STAGES-2:0], start & ~busy};
      out_strobe_r <= vld_r[PIPE_STAGES-1];
    end
  end

  // area, validity and exact right-angle test
  always_comb begin
    abs_cross = cross_prod[CROSS_W-1] ? CROSS_W'(-cross_prod) : CROSS_W'(cross_prod);
    sum1      = {1'b0, d2} + {1'b0, d3};
    sum2      = {1'b0, d1} + {1'b0, d3};
    sum3      = {1'b0, d1} + {1'b0, d2};
    side_nxt.valid_tri = (cross_prod != '0);
    side_nxt.area      = abs_cross[AREA_W-1:0];
    if (d1 > d2 && d1 > d3) begin
      side_nxt.is_right = ({1'b0, d1} == sum1);
    end else if (d2 > d1 && d2 > d3) begin
      side_nxt.is_right = ({1'b0, d2} == sum2);
    end else if (d3 > d1 && d3 > d2) begin
      side_nxt.is_right = ({1'b0, d3} == sum3);
    end else begin
      side_nxt.is_right = 1'b0;
    end
  end

  // side data rides beside the root stages
  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    for (int k = 1; k < SQ_STAGES; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // perimeter sum and zeroing of degenerate triangles
  always_comb begin
    out_data_nxt = '0;
    if (side_r[SQ_STAGES-1].valid_tri) begin
      out_data_nxt.valid_tri    = 1'b1;
      out_data_nxt.perimeter_q8 = PERIM_W'(r1) + PERIM_W'(r2) + PERIM_W'(r3);
      out_data_nxt.area_halves  = side_r[SQ_STAGES-1].area;
      out_data_nxt.is_right     = side_r[SQ_STAGES-1].is_right;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // degenerate result carries only zeros
  a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.valid_tri |->
      out_data.perimeter_q8 == '0 && out_data.area_halves == '0 && !out_data.is_right)
    else $error("invalid triangle with nonzero fields");

  // a valid triangle has nonzero area
  a_area_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.valid_tri == (out_data.area_halves != '0))
    else $error("valid flag disagrees with area");

  // a right angle only on a valid triangle
  a_right_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.is_right |-> out_data.valid_tri)
    else $error("right flag on invalid triangle");

endmodule
